### hdl/hrbp_pkg.sv
`default_nettype none

package hrbp_pkg;

	// Default width of the length accumulator and of the body counter.
	localparam int LENGTH_BITS_DEFAULT = 32;

	// Width of the body_length result field.
	localparam int BODY_LENGTH_W = 32;

	// Entries in the queue between the parser and the result stage.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		CLS_METHOD   = 3'd0,
		CLS_PATH     = 3'd1,
		CLS_VERSION  = 3'd2,
		CLS_HNAME    = 3'd3,
		CLS_HVALUE   = 3'd4,
		CLS_BODY     = 3'd5,
		CLS_COMPLETE = 3'd6,
		CLS_ERROR    = 3'd7
	} field_class_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_METHOD     = 2'd1,
		ERR_NEG_LENGTH = 2'd2
	} err_code_t;

	// One queue entry holds every result caused by one input byte.
	typedef struct packed {
		logic                     two;
		field_class_t             cls_a;
		logic [7:0]               byte_a;
		field_class_t             cls_b;
		logic [7:0]               byte_b;
		logic                     is_post;
		logic [BODY_LENGTH_W-1:0] body_length;
		err_code_t                error_code;
	} entry_t;

	// One result as it appears on the output ports.
	typedef struct packed {
		field_class_t             field_class;
		logic [7:0]               out_byte;
		logic                     is_post;
		logic [BODY_LENGTH_W-1:0] body_length;
		err_code_t                error_code;
		logic                     last_of_run;
	} result_t;

endpackage

`default_nettype wire

### hdl/hrbp_front.sv
`default_nettype none

module hrbp_front #(
	parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            q_full,
	input  logic [7:0]      in_byte,
	output logic            wr_en,
	output hrbp_pkg::entry_t wr_entry
);
	import hrbp_pkg::*;

	localparam int MAC_W = LENGTH_BITS + 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [3:0] CLEN_LEN = 4'd14;
	localparam logic [2:0] MPOS_MAX = 3'd7;
	localparam logic [2:0] GET_LEN  = 3'd3;
	localparam logic [2:0] POST_LEN = 3'd4;

	typedef enum logic [5:0] {
		PH_METHOD  = 6'b000001,
		PH_PATH    = 6'b000010,
		PH_VERSION = 6'b000100,
		PH_HNAME   = 6'b001000,
		PH_HVALUE  = 6'b010000,
		PH_BODY    = 6'b100000
	} phase_t;

	typedef enum logic [3:0] {
		LV_BLANKS = 4'b0001,
		LV_POS    = 4'b0010,
		LV_NEG    = 4'b0100,
		LV_DONE   = 4'b1000
	} lv_phase_t;

	function automatic logic [7:0] get_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0:    c = 8'h47;
			2'd1:    c = 8'h45;
			2'd2:    c = 8'h54;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] post_char(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0:    c = 8'h50;
			2'd1:    c = 8'h4F;
			2'd2:    c = 8'h53;
			default: c = 8'h54;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] clen_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	phase_t                 phase_q, phase_d;
	logic [2:0]             mpos_q, mpos_d;
	logic                   cand_get_q, cand_get_d;
	logic                   cand_post_q, cand_post_d;
	logic                   post_q, post_d;
	logic                   cr_q, cr_d;
	logic                   lstart_q, lstart_d;
	logic [3:0]             npos_q, npos_d;
	logic                   nmatch_q, nmatch_d;
	logic                   lseen_q, lseen_d;
	lv_phase_t              lvp_q, lvp_d;
	logic [LENGTH_BITS-1:0] accum_q, accum_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic                   err_q, err_d;

	logic                   accept;
	logic                   has_res;
	entry_t                 e;
	logic                   len_active;
	logic                   is_digit;
	logic                   is_blank;
	logic [MAC_W-1:0]       mac;
	logic [LENGTH_BITS-1:0] acc_sat;
	lv_phase_t              lvp_cr;
	lv_phase_t              feed_start;
	lv_phase_t              feed_lvp;
	logic [LENGTH_BITS-1:0] feed_acc;
	logic                   feed_ok;
	field_class_t           line_cls;

	assign accept     = push && !q_full;
	assign len_active = nmatch_q && (npos_q == CLEN_LEN);
	assign is_digit   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_blank   = (in_byte == CH_SP) || ((in_byte >= 8'd9) && (in_byte <= 8'd13));

	// Multiply by ten as two shifts and an add, then saturate on overflow.
	assign mac = (MAC_W'(accum_q) << 3) + (MAC_W'(accum_q) << 1) + MAC_W'(in_byte[3:0]);
	assign acc_sat = (mac[MAC_W-1:LENGTH_BITS] != '0) ? '1 : mac[LENGTH_BITS-1:0];

	// A CR fed to the conversion ends it once digits or a sign have begun.
	assign lvp_cr     = ((lvp_q == LV_POS) || (lvp_q == LV_NEG)) ? LV_DONE : lvp_q;
	assign feed_start = cr_q ? lvp_cr : lvp_q;
	assign feed_ok    = (phase_q == PH_HVALUE) && len_active;
	assign line_cls   = (phase_q == PH_VERSION) ? CLS_VERSION : CLS_HVALUE;

	always_comb begin
		feed_lvp = feed_start;
		feed_acc = accum_q;
		unique case (feed_start)
			LV_BLANKS: begin
				priority if (is_blank) begin
					feed_lvp = LV_BLANKS;
				end else if (in_byte == CH_PLUS) begin
					feed_lvp = LV_POS;
				end else if (in_byte == CH_MINUS) begin
					feed_lvp = LV_NEG;
				end else if (is_digit) begin
					feed_lvp = LV_POS;
					feed_acc = acc_sat;
				end else begin
					feed_lvp = LV_DONE;
				end
			end
			LV_POS, LV_NEG: begin
				if (is_digit) begin
					feed_acc = acc_sat;
				end else begin
					feed_lvp = LV_DONE;
				end
			end
			default: begin
				feed_lvp = LV_DONE;
			end
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		mpos_d      = mpos_q;
		cand_get_d  = cand_get_q;
		cand_post_d = cand_post_q;
		post_d      = post_q;
		cr_d        = cr_q;
		lstart_d    = lstart_q;
		npos_d      = npos_q;
		nmatch_d    = nmatch_q;
		lseen_d     = lseen_q;
		lvp_d       = lvp_q;
		accum_d     = accum_q;
		rem_d       = rem_q;
		err_d       = err_q;
		has_res     = 1'b0;

		e.two         = 1'b0;
		e.cls_a       = CLS_METHOD;
		e.byte_a      = 8'h00;
		e.cls_b       = CLS_METHOD;
		e.byte_b      = 8'h00;
		e.is_post     = post_q;
		e.body_length = BODY_LENGTH_W'(accum_q);
		e.error_code  = ERR_NONE;

		if (err_q) begin
			has_res      = 1'b1;
			e.cls_a      = CLS_ERROR;
			e.error_code = (phase_q == PH_METHOD) ? ERR_METHOD : ERR_NEG_LENGTH;
		end else begin
			unique case (phase_q)
				PH_PATH: begin
					if (in_byte == CH_SP) begin
						phase_d = PH_VERSION;
					end else begin
						has_res  = 1'b1;
						e.cls_a  = CLS_PATH;
						e.byte_a = in_byte;
					end
				end
				PH_VERSION, PH_HVALUE: begin
					if (cr_q) begin
						if (in_byte == CH_LF) begin
							cr_d = 1'b0;
							if (feed_ok && (lvp_q == LV_NEG) && (accum_q != '0)) begin
								err_d        = 1'b1;
								has_res      = 1'b1;
								e.cls_a      = CLS_ERROR;
								e.error_code = ERR_NEG_LENGTH;
							end else begin
								phase_d  = PH_HNAME;
								lstart_d = 1'b1;
								npos_d   = 4'd0;
								nmatch_d = 1'b1;
							end
						end else begin
							// The held CR turns out to be content.
							has_res  = 1'b1;
							e.cls_a  = line_cls;
							e.byte_a = CH_CR;
							if (in_byte == CH_CR) begin
								if (feed_ok) begin
									lvp_d = lvp_cr;
								end
							end else begin
								cr_d     = 1'b0;
								e.two    = 1'b1;
								e.cls_b  = line_cls;
								e.byte_b = in_byte;
								if (feed_ok) begin
									lvp_d   = feed_lvp;
									accum_d = feed_acc;
								end
							end
						end
					end else if (in_byte == CH_CR) begin
						cr_d = 1'b1;
					end else begin
						has_res  = 1'b1;
						e.cls_a  = line_cls;
						e.byte_a = in_byte;
						if (feed_ok) begin
							lvp_d   = feed_lvp;
							accum_d = feed_acc;
						end
					end
				end
				PH_HNAME: begin
					if (cr_q) begin
						cr_d = 1'b0;
						if (in_byte == CH_LF) begin
							if (post_q && (accum_q != '0)) begin
								phase_d = PH_BODY;
								rem_d   = accum_q;
							end else begin
								has_res     = 1'b1;
								e.cls_a     = CLS_COMPLETE;
								phase_d     = PH_METHOD;
								mpos_d      = 3'd0;
								cand_get_d  = 1'b1;
								cand_post_d = 1'b1;
								post_d      = 1'b0;
								lstart_d    = 1'b0;
								npos_d      = 4'd0;
								nmatch_d    = 1'b1;
								lseen_d     = 1'b0;
								lvp_d       = LV_BLANKS;
								accum_d     = '0;
								rem_d       = '0;
							end
						end else begin
							// A CR at line start never matches, so the name is dead.
							has_res  = 1'b1;
							e.cls_a  = CLS_HNAME;
							e.byte_a = CH_CR;
							lstart_d = 1'b0;
							nmatch_d = 1'b0;
							if (in_byte == CH_COLON) begin
								phase_d = PH_HVALUE;
							end else begin
								e.two    = 1'b1;
								e.cls_b  = CLS_HNAME;
								e.byte_b = in_byte;
							end
						end
					end else if (in_byte == CH_COLON) begin
						nmatch_d = len_active && !lseen_q;
						if (len_active && !lseen_q) begin
							lseen_d = 1'b1;
							lvp_d   = LV_BLANKS;
							accum_d = '0;
						end
						lstart_d = 1'b0;
						phase_d  = PH_HVALUE;
					end else if (lstart_q && (in_byte == CH_CR)) begin
						cr_d = 1'b1;
					end else begin
						has_res  = 1'b1;
						e.cls_a  = CLS_HNAME;
						e.byte_a = in_byte;
						lstart_d = 1'b0;
						if (nmatch_q) begin
							if ((npos_q < CLEN_LEN) && (in_byte == clen_char(npos_q))) begin
								npos_d = npos_q + 4'd1;
							end else begin
								nmatch_d = 1'b0;
							end
						end
					end
				end
				PH_BODY: begin
					has_res  = 1'b1;
					e.cls_a  = CLS_BODY;
					e.byte_a = in_byte;
					if (rem_q <= LENGTH_BITS'(1)) begin
						e.two       = 1'b1;
						e.cls_b     = CLS_COMPLETE;
						phase_d     = PH_METHOD;
						mpos_d      = 3'd0;
						cand_get_d  = 1'b1;
						cand_post_d = 1'b1;
						post_d      = 1'b0;
						cr_d        = 1'b0;
						lstart_d    = 1'b0;
						npos_d      = 4'd0;
						nmatch_d    = 1'b1;
						lseen_d     = 1'b0;
						lvp_d       = LV_BLANKS;
						accum_d     = '0;
						rem_d       = '0;
					end else begin
						rem_d = rem_q - LENGTH_BITS'(1);
					end
				end
				default: begin
					if (in_byte == CH_SP) begin
						if ((mpos_q == GET_LEN) && cand_get_q) begin
							post_d  = 1'b0;
							phase_d = PH_PATH;
						end else if ((mpos_q == POST_LEN) && cand_post_q) begin
							post_d  = 1'b1;
							phase_d = PH_PATH;
						end else begin
							err_d        = 1'b1;
							has_res      = 1'b1;
							e.cls_a      = CLS_ERROR;
							e.error_code = ERR_METHOD;
						end
					end else begin
						if (!((mpos_q < GET_LEN) && (in_byte == get_char(mpos_q[1:0])))) begin
							cand_get_d = 1'b0;
						end
						if (!((mpos_q < POST_LEN) && (in_byte == post_char(mpos_q[1:0])))) begin
							cand_post_d = 1'b0;
						end
						if (mpos_q != MPOS_MAX) begin
							mpos_d = mpos_q + 3'd1;
						end
						has_res  = 1'b1;
						e.cls_a  = CLS_METHOD;
						e.byte_a = in_byte;
					end
				end
			endcase
		end
	end

	assign wr_en    = accept && has_res;
	assign wr_entry = e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_METHOD;
			mpos_q      <= 3'd0;
			cand_get_q  <= 1'b1;
			cand_post_q <= 1'b1;
			post_q      <= 1'b0;
			cr_q        <= 1'b0;
			lstart_q    <= 1'b0;
			npos_q      <= 4'd0;
			nmatch_q    <= 1'b1;
			lseen_q     <= 1'b0;
			lvp_q       <= LV_BLANKS;
			accum_q     <= '0;
			rem_q       <= '0;
			err_q       <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			mpos_q      <= mpos_d;
			cand_get_q  <= cand_get_d;
			cand_post_q <= cand_post_d;
			post_q      <= post_d;
			cr_q        <= cr_d;
			lstart_q    <= lstart_d;
			npos_q      <= npos_d;
			nmatch_q    <= nmatch_d;
			lseen_q     <= lseen_d;
			lvp_q       <= lvp_d;
			accum_q     <= accum_d;
			rem_q       <= rem_d;
			err_q       <= err_d;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared without reset");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (rem_q != '0))
		else $error("body phase with nothing left to count");

	a_cr_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cr_q |-> ((phase_q == PH_VERSION) || (phase_q == PH_HVALUE) || (phase_q == PH_HNAME)))
		else $error("CR held outside a line phase");

endmodule

`default_nettype wire

### hdl/hrbp_queue.sv
`default_nettype none

module hrbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  hrbp_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             rd_en,
	output logic             rd_valid,
	output hrbp_pkg::entry_t rd_entry
);
	import hrbp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/hrbp_back.sv
`default_nettype none

module hrbp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  hrbp_pkg::entry_t  q_head,
	output logic              q_deq,
	input  logic              pop,
	output logic              empty,
	output hrbp_pkg::result_t res
);
	import hrbp_pkg::*;

	logic    out_valid_q;
	result_t out_q;
	logic    half_q;
	logic    load;
	result_t sel;

	assign load = q_valid && (!out_valid_q || pop);

	// half_q marks that the first of a two-result entry has been loaded into the output register.
	always_comb begin
		sel.is_post     = q_head.is_post;
		sel.body_length = q_head.body_length;
		if (!half_q) begin
			sel.field_class = q_head.cls_a;
			sel.out_byte    = q_head.byte_a;
			sel.error_code  = q_head.error_code;
			sel.last_of_run = !q_head.two;
			q_deq           = load && !q_head.two;
		end else begin
			sel.field_class = q_head.cls_b;
			sel.out_byte    = q_head.byte_b;
			sel.error_code  = ERR_NONE;
			sel.last_of_run = 1'b1;
			q_deq           = load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				half_q      <= !half_q && q_head.two;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign res   = out_q;

	a_half_head: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> q_valid)
		else $error("second result pending without a queue entry");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.field_class == CLS_ERROR)) |-> out_q.last_of_run)
		else $error("error result not last of its run");

	a_code_only_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.field_class != CLS_ERROR)) |-> (out_q.error_code == ERR_NONE))
		else $error("error code on a non-error result");

endmodule

`default_nettype wire

### hdl/http_request_byte_parser.sv
// HTTP request byte parser. Request bytes enter through a queue-style port
// (push/full) and every content byte comes back out through a second queue-
// style port (empty/pop), tagged as method, path, version, header name, header
// value or body, together with the recognized method (GET or POST), the
// Content-Length value parsed so far and, at the end of a request, a complete
// result after which the parser rearms for the next request. Separators (the
// spaces of the request line, the header colon and each CR LF) produce no
// result; a CR in the version or a header value is held until the next byte
// shows whether it began a CR LF. An unknown method or a negative length gives
// an error result for every later byte until reset. Timing: a byte is taken
// at any edge where full is low, one byte per cycle, and the parser decides
// everything about it in that cycle. The results of a byte sit in a four-entry
// queue and then pass through the output register to the result ports; one
// result leaves per cycle while pop is high, so a byte that causes two results
// (a held CR flushed together with the next byte, or the last body byte
// followed by the completion) gives two results, and the output port's rate
// is what bounds the sustained input rate. The parser's state update, with
// its multiply-by-ten accumulate of the length, is the longest path.
`default_nettype none

module http_request_byte_parser #(
	parameter int LENGTH_BITS = hrbp_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  field_class,
	output logic [7:0]  out_byte,
	output logic        is_post,
	output logic [31:0] body_length,
	output logic [1:0]  error_code,
	output logic        last_of_run
);
	import hrbp_pkg::*;

	// Front to queue: one entry per byte that causes at least one result.
	logic    wr_en;
	entry_t  wr_entry;

	// Queue to back: the oldest entry and the dequeue strobe.
	logic    rd_valid;
	logic    rd_en;
	entry_t  rd_entry;

	result_t res;

	// The parser: classifies each byte and keeps all per-request state.
	hrbp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_full   (full),
		.in_byte  (in_byte),
		.wr_en    (wr_en),
		.wr_entry (wr_entry)
	);

	// Short queue that lets the parser keep taking bytes while results wait.
	hrbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.full     (full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_entry (rd_entry)
	);

	// The result stage: splits each entry into its one or two results and
	// holds the oldest one in an output register until its transfer.
	hrbp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (rd_valid),
		.q_head  (rd_entry),
		.q_deq   (rd_en),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign field_class = res.field_class;
	assign out_byte    = res.out_byte;
	assign is_post     = res.is_post;
	assign body_length = res.body_length;
	assign error_code  = res.error_code;
	assign last_of_run = res.last_of_run;

endmodule

`default_nettype wire

### tb/hrbp_checker.sv
module hrbp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  in_byte,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  field_class,
	input  logic [7:0]  out_byte,
	input  logic        is_post,
	input  logic [31:0] body_length,
	input  logic [1:0]  error_code,
	input  logic        last_of_run,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import hrbp_pkg::*;

	typedef enum logic [2:0] {
		PH_METHOD, PH_PATH, PH_VERSION, PH_HNAME, PH_HVALUE, PH_BODY
	} parse_phase_t;

	typedef enum logic [1:0] {
		LV_BLANKS, LV_POSITIVE, LV_NEGATIVE, LV_DONE
	} length_state_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam int CLEN_LEN = 14;
	localparam logic [8*3-1:0]        TXT_GET  = "GET";
	localparam logic [8*4-1:0]        TXT_POST = "POST";
	localparam logic [8*CLEN_LEN-1:0] TXT_CLEN = "Content-Length";
	localparam logic [31:0]           LENGTH_MAX = 32'hFFFF_FFFF;

	parse_phase_t  phase;
	logic [2:0]    method_pos;
	logic          get_possible;
	logic          post_possible;
	logic          post_flag;
	logic          cr_held;
	logic          line_start;
	logic [3:0]    name_pos;
	logic          name_matching;
	logic          length_seen;
	length_state_t length_state;
	logic [31:0]   length_acc;
	logic [31:0]   body_left;
	logic          err_latched;

	result_t byte_results[$];
	result_t expected_results[$];

	function automatic logic [7:0] text_char(input logic [8*CLEN_LEN-1:0] txt, input int len,
			input int i);
		if (i >= len)
			return 8'h00;
		return txt[8*(len-1-i) +: 8];
	endfunction

	function automatic void emit(input field_class_t cls, input logic [7:0] b);
		result_t r;
		r.field_class = cls;
		r.out_byte    = (cls <= CLS_BODY) ? b : 8'h00;
		r.is_post     = post_flag;
		r.body_length = length_acc;
		r.error_code  = (cls != CLS_ERROR) ? ERR_NONE :
			(phase == PH_METHOD) ? ERR_METHOD : ERR_NEG_LENGTH;
		r.last_of_run = 1'b0;
		byte_results.push_back(r);
	endfunction

	function automatic void rearm();
		phase         = PH_METHOD;
		method_pos    = '0;
		get_possible  = 1'b1;
		post_possible = 1'b1;
		post_flag     = 1'b0;
		cr_held       = 1'b0;
		line_start    = 1'b0;
		name_pos      = '0;
		name_matching = 1'b1;
		length_seen   = 1'b0;
		length_state  = LV_BLANKS;
		length_acc    = '0;
		body_left     = '0;
	endfunction

	function automatic logic length_active();
		return name_matching && name_pos == CLEN_LEN;
	endfunction

	// atoi-style conversion of the Content-Length value, saturating at the top.
	function automatic void feed_length(input logic [7:0] b);
		logic        digit;
		logic [63:0] d;
		digit = (b >= CH_ZERO && b <= CH_NINE);
		if (!length_active() || length_state == LV_DONE)
			return;
		if (length_state == LV_BLANKS) begin
			if (b == CH_SP || (b >= CH_TAB && b <= CH_CR))
				return;
			if (b == CH_PLUS) begin
				length_state = LV_POSITIVE;
				return;
			end
			if (b == CH_MINUS) begin
				length_state = LV_NEGATIVE;
				return;
			end
			if (!digit) begin
				length_state = LV_DONE;
				return;
			end
			length_state = LV_POSITIVE;
		end
		if (!digit) begin
			length_state = LV_DONE;
			return;
		end
		d = 64'(b - CH_ZERO);
		if (64'(length_acc) > (64'(LENGTH_MAX) - d) / 10)
			length_acc = LENGTH_MAX;
		else
			length_acc = 32'(64'(length_acc) * 10 + d);
	endfunction

	function automatic void line_content(input logic [7:0] b);
		if (phase == PH_VERSION) begin
			emit(CLS_VERSION, b);
		end else begin
			emit(CLS_HVALUE, b);
			feed_length(b);
		end
	endfunction

	function automatic void name_byte(input logic [7:0] b);
		line_start = 1'b0;
		if (name_matching) begin
			if (name_pos < CLEN_LEN && b == text_char(TXT_CLEN, CLEN_LEN, int'(name_pos)))
				name_pos++;
			else
				name_matching = 1'b0;
		end
		emit(CLS_HNAME, b);
	endfunction

	function automatic void start_header_line();
		phase         = PH_HNAME;
		line_start    = 1'b1;
		name_pos      = '0;
		name_matching = 1'b1;
	endfunction

	function automatic void line_end();
		cr_held = 1'b0;
		if (phase == PH_HVALUE && length_active() && length_state == LV_NEGATIVE &&
				length_acc != 0) begin
			err_latched = 1'b1;
			emit(CLS_ERROR, 8'h00);
			return;
		end
		start_header_line();
	endfunction

	function automatic void step_line(input logic [7:0] b);
		if (cr_held) begin
			if (b == CH_LF) begin
				line_end();
				return;
			end
			line_content(CH_CR);
			if (b == CH_CR)
				return;
			cr_held = 1'b0;
			line_content(b);
			return;
		end
		if (b == CH_CR) begin
			cr_held = 1'b1;
			return;
		end
		line_content(b);
	endfunction

	function automatic void step_name(input logic [7:0] b);
		logic act;
		if (cr_held) begin
			cr_held = 1'b0;
			if (b == CH_LF) begin
				// Blank line: a POST with a length goes on to its body.
				if (post_flag && length_acc != 0) begin
					phase     = PH_BODY;
					body_left = length_acc;
					return;
				end
				emit(CLS_COMPLETE, 8'h00);
				rearm();
				return;
			end
			name_byte(CH_CR);
		end
		if (b == CH_COLON) begin
			act = length_active() && !length_seen;
			name_matching = act;
			if (act) begin
				length_seen  = 1'b1;
				length_state = LV_BLANKS;
				length_acc   = '0;
			end
			line_start = 1'b0;
			phase      = PH_HVALUE;
			return;
		end
		if (line_start && b == CH_CR) begin
			cr_held = 1'b1;
			return;
		end
		name_byte(b);
	endfunction

	function automatic void step_method(input logic [7:0] b);
		if (b == CH_SP) begin
			if (method_pos == 3 && get_possible) begin
				post_flag = 1'b0;
			end else if (method_pos == 4 && post_possible) begin
				post_flag = 1'b1;
			end else begin
				err_latched = 1'b1;
				emit(CLS_ERROR, 8'h00);
				return;
			end
			phase = PH_PATH;
			return;
		end
		if (!(method_pos < 3 && b == text_char(TXT_GET, 3, int'(method_pos))))
			get_possible = 1'b0;
		if (!(method_pos < 4 && b == text_char(TXT_POST, 4, int'(method_pos))))
			post_possible = 1'b0;
		if (method_pos < 7)
			method_pos++;
		emit(CLS_METHOD, b);
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		result_t r;
		byte_results.delete();
		if (err_latched) begin
			emit(CLS_ERROR, 8'h00);
		end else begin
			case (phase)
				PH_PATH: begin
					if (b == CH_SP)
						phase = PH_VERSION;
					else
						emit(CLS_PATH, b);
				end
				PH_VERSION, PH_HVALUE: begin
					step_line(b);
				end
				PH_HNAME: begin
					step_name(b);
				end
				PH_BODY: begin
					emit(CLS_BODY, b);
					if (body_left != 0)
						body_left--;
					if (body_left == 0) begin
						emit(CLS_COMPLETE, 8'h00);
						rearm();
					end
				end
				default: begin
					step_method(b);
				end
			endcase
		end
		if (byte_results.size() > 0) begin
			r = byte_results.pop_back();
			r.last_of_run = 1'b1;
			byte_results.push_back(r);
		end
		foreach (byte_results[i])
			expected_results.push_back(byte_results[i]);
	endfunction

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want_r;
		if (!arst_n) begin
			rearm();
			err_latched = 1'b0;
			expected_results.delete();
			outstanding = 0;
		end else begin
			// A result leaves before the byte of the same edge can have produced anything.
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual class %0d byte %0h",
						$time, field_class, out_byte);
					fail_count++;
				end else begin
					want_r = expected_results.pop_front();
					compare_field("field_class", 32'(want_r.field_class), 32'(field_class));
					compare_field("out_byte", 32'(want_r.out_byte), 32'(out_byte));
					compare_field("is_post", 32'(want_r.is_post), 32'(is_post));
					compare_field("body_length", want_r.body_length, body_length);
					compare_field("error_code", 32'(want_r.error_code), 32'(error_code));
					compare_field("last_of_run", 32'(want_r.last_of_run), 32'(last_of_run));
				end
			end
			if (push && !full)
				predict_byte(in_byte);
			outstanding = expected_results.size();
		end
	end

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hrbp_pkg::*;

	// The run stops on its own long before this many cycles unless the block hangs.
	localparam int CYCLE_LIMIT = 500_000;
	// Random requests are generated until roughly this many bytes have been transferred.
	localparam int BYTE_TARGET = 1900;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_COLON = 8'h3A;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  in_byte;
	logic        empty;
	logic        pop;
	logic [2:0]  field_class;
	logic [7:0]  out_byte;
	logic        is_post;
	logic [31:0] body_length;
	logic [1:0]  error_code;
	logic        last_of_run;

	int fail_count;
	int outstanding;
	int burst_left  = 0;
	int sent_count  = 0;
	int cycle_count = 0;

	http_request_byte_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.empty       (empty),
		.pop         (pop),
		.field_class (field_class),
		.out_byte    (out_byte),
		.is_post     (is_post),
		.body_length (body_length),
		.error_code  (error_code),
		.last_of_run (last_of_run)
	);

	// The checker watches both queue ports, predicts every result and reports failures.
	hrbp_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_byte     (in_byte),
		.empty       (empty),
		.pop         (pop),
		.field_class (field_class),
		.out_byte    (out_byte),
		.is_post     (is_post),
		.body_length (body_length),
		.error_code  (error_code),
		.last_of_run (last_of_run),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// The receiver changes its behavior after a random span of cycles. Sometimes it takes every
	// result, sometimes it pops at random, sometimes rarely, and sometimes it holds pop low
	// for a random run between single transfers.
	initial begin
		int mode;
		int span;
		int hold;
		pop = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			hold = 0;
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: begin
						if (hold == 0) begin
							hold = $urandom_range(1, 8);
							pop <= 1'b1;
						end else begin
							hold--;
							pop <= 1'b0;
						end
					end
				endcase
			end
		end
	end

	function automatic logic [7:0] rand_byte_not(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		do
			r = 8'($urandom_range(0, 255));
		while (r == a || r == b);
		return r;
	endfunction

	// Every call starts and ends at a falling edge. The sender works in bursts: when a burst
	// runs out it may drop push for a random gap before the next one starts. A zero-length
	// gap is common, so long stretches go by with push held high. The byte is presented
	// until a rising edge sees full low, which is when the transfer happens.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push    <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_crlf();
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	// A line of arbitrary bytes that never contains CR LF, closed by CR LF. A stray CR
	// inside, or right before the closing CR LF, exercises the held-CR logic.
	task automatic send_free_line(input int n);
		logic [7:0] prev;
		logic [7:0] b;
		prev = 8'h00;
		repeat (n) begin
			do
				b = 8'($urandom_range(0, 255));
			while (prev == CH_CR && b == CH_LF);
			send_byte(b);
			prev = b;
		end
		send_crlf();
	endtask

	// A random header name. It never holds a colon, and it does not open with a CR, so it
	// cannot be mistaken for the blank line.
	task automatic send_name();
		send_byte(rand_byte_not(CH_COLON, CH_CR));
		repeat ($urandom_range(0, 5))
			send_byte(rand_byte_not(CH_COLON, CH_COLON));
	endtask

	// Sends a Content-Length value line and returns the magnitude that the block should
	// accumulate from it, or zero for the large values. Leading blanks, a plus sign,
	// leading zeros and trailing junk all appear. A minus sign only comes with a zero value
	// or with junk that ends the number before the line does, so no error is raised here.
	// Values that overflow the counter are only sent where they cannot turn into a body.
	task automatic send_length_value(input bit allow_big, output int unsigned value);
		int k;
		int mode;
		int v;
		value = 0;
		repeat ($urandom_range(0, 2)) begin
			k = $urandom_range(0, 5);
			if (k == 0) begin
				send_byte(CH_SP);
			end else if (k == 5) begin
				send_byte(CH_CR);
				send_byte(CH_SP);
			end else begin
				// Tab, line feed, vertical tab or form feed.
				send_byte(8'(8 + k));
			end
		end
		mode = $urandom_range(0, 9);
		if (mode == 6 && !allow_big)
			mode = 0;
		case (mode)
			6: begin
				k = $urandom_range(0, 3);
				if (k == 0)
					send_text("4294967295");
				else if (k == 1)
					send_text("4294967296");
				else if (k == 2)
					send_text("99999999999999999999");
				else
					send_text($sformatf("%0d%0d", $urandom, $urandom));
			end
			7: begin
				send_text("-0");
			end
			8: begin
				v = $urandom_range(0, 9);
				send_byte(CH_MINUS);
				if (v != 0) begin
					send_text($sformatf("%0dx", v));
					value = v;
				end
			end
			9: begin
				if ($urandom_range(0, 1) == 0)
					send_text("abc");
				else
					send_text("+-5");
			end
			default: begin
				v = $urandom_range(0, 12);
				if ($urandom_range(0, 3) == 0)
					send_byte(CH_PLUS);
				if ($urandom_range(0, 3) == 0)
					send_byte(CH_ZERO);
				send_text($sformatf("%0d", v));
				if ($urandom_range(0, 3) == 0)
					send_text("x7");
				value = v;
			end
		endcase
		send_crlf();
	endtask

	// One well-formed request with random content: method, path, version, up to four
	// headers (plain, Content-Length, or a name that almost matches), the blank line and,
	// for a POST whose first Content-Length is nonzero, exactly that many body bytes.
	task automatic send_request();
		bit          post;
		bit          have_len;
		int          kind;
		int unsigned first_len;
		int unsigned v;
		post      = 1'($urandom_range(0, 1));
		have_len  = 1'b0;
		first_len = 0;
		if (post)
			send_text("POST ");
		else
			send_text("GET ");
		repeat ($urandom_range(0, 6))
			send_byte(rand_byte_not(CH_SP, CH_SP));
		send_byte(CH_SP);
		send_free_line($urandom_range(0, 6));
		repeat ($urandom_range(0, 4)) begin
			kind = $urandom_range(0, 4);
			if (kind <= 1) begin
				send_name();
				send_byte(CH_COLON);
				send_free_line($urandom_range(0, 8));
			end else if (kind <= 3) begin
				// Only the first one counts; a repeat may carry any value.
				send_text("Content-Length:");
				send_length_value(!post || have_len, v);
				if (!have_len) begin
					first_len = v;
					have_len  = 1'b1;
				end
			end else begin
				k_near_miss();
				send_byte(CH_COLON);
				send_free_line($urandom_range(0, 8));
			end
		end
		send_crlf();
		if (post)
			repeat (first_len) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic k_near_miss();
		case ($urandom_range(0, 3))
			0: send_text("Content-Lengt");
			1: send_text("content-length");
			2: send_text("Content-Lengthx");
			default: send_text(" Content-Length");
		endcase
	endtask

	// Holds the sender off until every predicted result has come out.
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	initial begin
		int req;
		arst_n  = 1'b0;
		push    = 1'b0;
		in_byte = 8'h00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A GET whose path holds the largest and smallest byte values and
		// whose version holds CR CR and a CR followed by another byte. The request line is
		// followed directly by the blank line, so there are no headers.
		send_text("GET ");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CH_SP);
		send_byte(CH_CR);
		send_byte(CH_CR);
		send_byte(8'h01);
		send_crlf();
		send_crlf();
		// A POST with an empty path and an empty version. Its one header name opens with a
		// CR that is not followed by LF, and it has no Content-Length, so the request ends
		// at the blank line without a body.
		send_text("POST ");
		send_byte(CH_SP);
		send_crlf();
		send_byte(CH_CR);
		send_text("A:");
		send_byte(8'h80);
		send_byte(8'h7F);
		send_crlf();
		send_crlf();
		wait_drained();

		// Random part. Requests are always well formed at the method and the length, since
		// an error is sticky and reset happens only once; the content is random throughout.
		req = 0;
		while (sent_count < BYTE_TARGET) begin
			send_request();
			req++;
			if (req == 12 || $urandom_range(0, 24) == 0)
				wait_drained();
		end

		// The run ends on one of the two errors, chosen at random. Every byte after it must
		// keep giving the same error.
		if ($urandom_range(0, 1) == 0) begin
			case ($urandom_range(0, 4))
				0: ;
				1: send_text("GE");
				2: send_text("POSTT");
				3: send_text("get");
				default: begin
					repeat ($urandom_range(1, 9))
						send_byte(rand_byte_not(CH_SP, CH_SP));
				end
			endcase
			send_byte(CH_SP);
		end else begin
			send_text("POST / v");
			send_crlf();
			send_text("Content-Length: -");
			send_text($sformatf("%0d", $urandom_range(1, 99999)));
			send_crlf();
		end
		repeat (12)
			send_byte(8'($urandom_range(0, 255)));

		// Drain, then keep the run going so that any result the block should not have shows.
		push <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
